FILE: design/assert_macros.svh
// assertion macros shared by the demand distribution design
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property with a synchronous reset that disables it
`define TDDP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property that holds through reset as well
`define TDDP_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDDP_ASSERT(label, clk, rst, prop, msg)
`define TDDP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: design/tddp_pkg.sv
// types, codes and fixed-point helpers of the demand distribution block
// no dependencies
package tddp_pkg;

   localparam int MODE_W  = 2;
   localparam int LEVEL_W = 5;
   localparam int PROB_W  = 17;
   localparam int TOTAL_W = 11;
   localparam int DIST_W  = 32;
   localparam int TERM_W  = 33;
   localparam int ACC_W   = 38;

   localparam logic [MODE_W-1:0] MODE_START = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

   localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
   localparam logic [DIST_W-1:0] ONE_Q31 = 32'h8000_0000;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [LEVEL_W-1:0] demand_level;
      logic [PROB_W-1:0]  level_prob;
      logic [PROB_W-1:0]  presence_prob;
      logic [TOTAL_W-1:0] total_demand;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] probability;
      logic              route_full;
   } rsp_type;

   // control of the distribution store
   typedef struct packed {
      logic clear;
      logic rd_en;
      logic rd_zero;
   } dist_cmd_type;

   // markers travelling with one term through the multiply-accumulate pipe
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } term_tag_type;

   function automatic logic [PROB_W-1:0] sat_q16(input logic [PROB_W-1:0] v);
      return (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

   function automatic logic [DIST_W-1:0] sat_q31(input logic [ACC_W-1:0] v);
      return (v > ACC_W'(ONE_Q31)) ? ONE_Q31 : v[DIST_W-1:0];
   endfunction

endpackage

FILE: design/tddp_dist_store.sv
// distribution store: single-port-read, single-port-write memory of Q1.31 entries
// uses tddp_pkg; entries above the current top read as zero, entry zero reads one after a clear
module tddp_dist_store #(
   parameter int DEPTH = 1281
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tddp_pkg::dist_cmd_type      cmd,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [tddp_pkg::DIST_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [tddp_pkg::DIST_W-1:0] wr_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [tddp_pkg::DIST_W-1:0] mem [DEPTH];
   logic [tddp_pkg::DIST_W-1:0] mem_q_ff;
   logic                        zero_q_ff;
   logic                        one_q_ff;
   logic                        fresh_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // entry zero holds one until the first fold writes it
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff  <= 1'b1;
         zero_q_ff <= 1'b0;
         one_q_ff  <= 1'b0;
      end else begin
         if (cmd.clear) begin
            fresh_ff <= 1'b1;
         end else if (wr_en && wr_addr == ADDR_W'(0)) begin
            fresh_ff <= 1'b0;
         end
         if (cmd.rd_en) begin
            zero_q_ff <= cmd.rd_zero;
            one_q_ff  <= fresh_ff && rd_addr == ADDR_W'(0);
         end
      end
   end

   assign rd_data = zero_q_ff ? '0 : (one_q_ff ? tddp_pkg::ONE_Q31 : mem_q_ff);

endmodule

FILE: design/tddp_pmf_store.sv
// demand level probabilities: small memory with a valid bit per entry
// uses tddp_pkg; an entry never loaded since reset reads as zero
module tddp_pmf_store #(
   parameter int DEPTH = 20
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_index,
   input  logic [tddp_pkg::PROB_W-1:0]              wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_index,
   output logic [tddp_pkg::PROB_W-1:0]              rd_data
);

   logic [tddp_pkg::PROB_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]            valid_ff;
   logic [tddp_pkg::PROB_W-1:0] mem_q_ff;
   logic                        valid_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_index] <= wr_data;
      end
      mem_q_ff <= mem[rd_index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_q_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_index] <= 1'b1;
         end
         valid_q_ff <= valid_ff[rd_index];
      end
   end

   assign rd_data = valid_q_ff ? mem_q_ff : '0;

endmodule

FILE: design/tddp_mac.sv
// three-stage multiply-accumulate pipe of the fold: weight, product, sum and write back
// uses tddp_pkg; operands from the two stores arrive in the cycle after issue
module tddp_mac #(
   parameter int ADDR_W = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tddp_pkg::term_tag_type      issue_tag,
   input  logic [ADDR_W-1:0]           issue_addr,
   input  logic [tddp_pkg::PROB_W-1:0] presence,
   input  logic [tddp_pkg::PROB_W-1:0] absent,
   input  logic [tddp_pkg::PROB_W-1:0] pmf_q,
   input  logic [tddp_pkg::DIST_W-1:0] dist_q,
   output logic                        busy,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [tddp_pkg::DIST_W-1:0] wr_data
);

   localparam int WP_W = 2 * tddp_pkg::PROB_W;
   localparam int PR_W = 2 * tddp_pkg::DIST_W;

   tddp_pkg::term_tag_type a_tag_ff;
   tddp_pkg::term_tag_type b_tag_ff;
   tddp_pkg::term_tag_type c_tag_ff;
   logic [ADDR_W-1:0]           a_addr_ff;
   logic [ADDR_W-1:0]           b_addr_ff;
   logic [ADDR_W-1:0]           c_addr_ff;
   logic [tddp_pkg::DIST_W-1:0] b_coef_ff;
   logic [tddp_pkg::DIST_W-1:0] b_old_ff;
   logic [tddp_pkg::TERM_W-1:0] c_term_ff;
   logic [tddp_pkg::ACC_W-1:0]  acc_ff;

   logic [WP_W-1:0]             weight_full;
   logic [tddp_pkg::DIST_W-1:0] coef_in;
   logic [PR_W-1:0]             product;
   logic [tddp_pkg::TERM_W-1:0] term_in;
   logic [tddp_pkg::ACC_W-1:0]  acc_in;

   // present weight is p * pmf >> 1 in Q1.31, absent weight stays Q1.16
   assign weight_full = WP_W'(presence) * WP_W'(pmf_q);
   assign coef_in     = a_tag_ff.first ? tddp_pkg::DIST_W'(absent)
                                       : weight_full[tddp_pkg::DIST_W:1];

   assign product = PR_W'(b_coef_ff) * PR_W'(b_old_ff);
   assign term_in = b_tag_ff.first ? product[48:16] : product[63:31];

   assign acc_in = c_tag_ff.first ? tddp_pkg::ACC_W'(c_term_ff)
                                  : acc_ff + tddp_pkg::ACC_W'(c_term_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         c_tag_ff <= '0;
      end else begin
         a_tag_ff <= issue_tag;
         b_tag_ff <= a_tag_ff;
         c_tag_ff <= b_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_addr_ff <= issue_addr;
      b_addr_ff <= a_addr_ff;
      c_addr_ff <= b_addr_ff;
      b_coef_ff <= coef_in;
      b_old_ff  <= dist_q;
      c_term_ff <= term_in;
      if (c_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign busy    = a_tag_ff.valid || b_tag_ff.valid || c_tag_ff.valid;
   assign wr_en   = c_tag_ff.valid && c_tag_ff.last;
   assign wr_addr = c_addr_ff;
   assign wr_data = tddp_pkg::sat_q31(acc_in);

endmodule

FILE: design/total_demand_distribution_dp_top.sv
// Total demand distribution along a route: a store of MAX_DEMAND*MAX_CUSTOMERS+1 Q1.31
// probabilities, updated in place one customer at a time. Start and load requests go from
// idle to the reply state, a query through a read state first, and a reply waits while the
// previous response is not yet taken. An add folds the customer in from the highest
// reachable total T = MAX_DEMAND*(customers so far + 1) down to zero, min(t, MAX_DEMAND) + 1
// terms for each total t, one term per cycle through the single distribution read port
// and one 32x32 multiplier, then waits for the pipe to drain. There is no clearing pass
// after reset or start: totals above the reachable top read as zero.
// Uses tddp_pkg, tddp_dist_store, tddp_pmf_store, tddp_mac and assert_macros.svh.
`include "assert_macros.svh"

module total_demand_distribution_dp_top #(
   parameter int MAX_CUSTOMERS = 64,
   parameter int MAX_DEMAND    = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tddp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tddp_pkg::rsp_type rsp_data
);

   localparam int DEPTH  = MAX_DEMAND * MAX_CUSTOMERS + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CUST_W = $clog2(MAX_CUSTOMERS + 1);
   localparam int K_W    = $clog2(MAX_DEMAND + 1);
   localparam int PMF_AW = MAX_DEMAND > 1 ? $clog2(MAX_DEMAND) : 1;
   localparam int CMP_W  = ADDR_W > tddp_pkg::TOTAL_W ? ADDR_W : tddp_pkg::TOTAL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUERY,
      ST_FOLD,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   state_type                   state_ff;
   logic [CUST_W-1:0]           customers_ff;
   logic [ADDR_W-1:0]           limit_ff;
   logic [ADDR_W-1:0]           t_ff;
   logic [K_W-1:0]              k_ff;
   logic [tddp_pkg::PROB_W-1:0] presence_ff;
   logic [tddp_pkg::PROB_W-1:0] absent_ff;
   tddp_pkg::rsp_type           res_ff;
   logic                        rsp_valid_ff;
   tddp_pkg::rsp_type           rsp_data_ff;

   logic                        accept;
   logic                        level_ok;
   logic                        route_full_now;
   logic [tddp_pkg::PROB_W-1:0] presence_sat;
   logic [K_W-1:0]              k_max;
   logic                        term_last;
   logic [ADDR_W-1:0]           fold_addr;
   logic                        query_oob;

   tddp_pkg::dist_cmd_type      dist_cmd;
   logic [ADDR_W-1:0]           dist_rd_addr;
   logic [tddp_pkg::DIST_W-1:0] dist_q;
   logic                        pmf_wr_en;
   logic [PMF_AW-1:0]           pmf_wr_index;
   logic [PMF_AW-1:0]           pmf_rd_index;
   logic [tddp_pkg::PROB_W-1:0] pmf_q;
   tddp_pkg::term_tag_type      issue_tag;
   logic                        mac_busy;
   logic                        mac_wr_en;
   logic [ADDR_W-1:0]           mac_wr_addr;
   logic [tddp_pkg::DIST_W-1:0] mac_wr_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign level_ok = req_data.demand_level != '0 &&
                     32'(req_data.demand_level) <= MAX_DEMAND;
   assign route_full_now = 32'(customers_ff) >= MAX_CUSTOMERS;
   assign presence_sat = tddp_pkg::sat_q16(req_data.presence_prob);

   // terms run k = 0 (absent) up to min(t, MAX_DEMAND)
   assign k_max     = (t_ff < ADDR_W'(MAX_DEMAND)) ? K_W'(t_ff) : K_W'(MAX_DEMAND);
   assign term_last = (k_ff == k_max);
   assign fold_addr = t_ff - ADDR_W'(k_ff);
   assign query_oob = CMP_W'(req_data.total_demand) > CMP_W'(limit_ff);

   // reads stay at or below t while write-back lands above it, so no forwarding
   always_comb begin
      dist_cmd.clear   = accept && req_data.mode == tddp_pkg::MODE_START;
      dist_cmd.rd_en   = 1'b0;
      dist_cmd.rd_zero = 1'b0;
      dist_rd_addr     = fold_addr;
      if (state_ff == ST_FOLD) begin
         dist_cmd.rd_en   = 1'b1;
         dist_cmd.rd_zero = fold_addr > limit_ff;
      end else if (accept && req_data.mode == tddp_pkg::MODE_QUERY) begin
         dist_cmd.rd_en   = 1'b1;
         dist_cmd.rd_zero = query_oob;
         dist_rd_addr     = ADDR_W'(req_data.total_demand);
      end
   end

   assign pmf_wr_en    = accept && req_data.mode == tddp_pkg::MODE_LOAD && level_ok;
   assign pmf_wr_index = PMF_AW'(req_data.demand_level - tddp_pkg::LEVEL_W'(1));
   assign pmf_rd_index = (k_ff == '0) ? '0 : PMF_AW'(k_ff - K_W'(1));

   assign issue_tag.valid = (state_ff == ST_FOLD);
   assign issue_tag.first = (k_ff == '0);
   assign issue_tag.last  = term_last;

   tddp_dist_store #(
      .DEPTH (DEPTH)
   ) u_dist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dist_cmd),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_q),
      .wr_en   (mac_wr_en),
      .wr_addr (mac_wr_addr),
      .wr_data (mac_wr_data)
   );

   tddp_pmf_store #(
      .DEPTH (MAX_DEMAND)
   ) u_pmf (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pmf_wr_en),
      .wr_index (pmf_wr_index),
      .wr_data  (tddp_pkg::sat_q16(req_data.level_prob)),
      .rd_index (pmf_rd_index),
      .rd_data  (pmf_q)
   );

   tddp_mac #(
      .ADDR_W (ADDR_W)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .issue_tag  (issue_tag),
      .issue_addr (t_ff),
      .presence   (presence_ff),
      .absent     (absent_ff),
      .pmf_q      (pmf_q),
      .dist_q     (dist_q),
      .busy       (mac_busy),
      .wr_en      (mac_wr_en),
      .wr_addr    (mac_wr_addr),
      .wr_data    (mac_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         customers_ff <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_REPLY) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  res_ff.probability <= '0;
                  res_ff.route_full  <= req_data.mode == tddp_pkg::MODE_ADD && route_full_now;
                  case (req_data.mode)
                     tddp_pkg::MODE_START: begin
                        customers_ff <= '0;
                        limit_ff     <= '0;
                        state_ff     <= ST_REPLY;
                     end
                     tddp_pkg::MODE_ADD: begin
                        if (route_full_now) begin
                           state_ff <= ST_REPLY;
                        end else begin
                           presence_ff <= presence_sat;
                           absent_ff   <= tddp_pkg::ONE_Q16 - presence_sat;
                           t_ff        <= limit_ff + ADDR_W'(MAX_DEMAND);
                           k_ff        <= '0;
                           state_ff    <= ST_FOLD;
                        end
                     end
                     tddp_pkg::MODE_QUERY: begin
                        state_ff <= ST_QUERY;
                     end
                     default: begin
                        state_ff <= ST_REPLY;
                     end
                  endcase
               end
            end
            ST_QUERY: begin
               res_ff.probability <= dist_q;
               state_ff           <= ST_REPLY;
            end
            ST_FOLD: begin
               if (term_last) begin
                  k_ff <= '0;
                  if (t_ff == '0) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     t_ff <= t_ff - ADDR_W'(1);
                  end
               end else begin
                  k_ff <= k_ff + K_W'(1);
               end
            end
            ST_DRAIN: begin
               if (!mac_busy) begin
                  customers_ff <= customers_ff + CUST_W'(1);
                  limit_ff     <= limit_ff + ADDR_W'(MAX_DEMAND);
                  state_ff     <= ST_REPLY;
               end
            end
            ST_REPLY: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `TDDP_ASSERT_NR(a_reset_idle, clock, $past(reset) |-> (state_ff == ST_IDLE && !rsp_valid_ff), "not idle after reset")
   `TDDP_ASSERT(a_no_rw_overlap, clock, reset, (mac_wr_en && dist_cmd.rd_en) |-> (mac_wr_addr != dist_rd_addr), "read and write-back hit the same total")
   `TDDP_ASSERT(a_limit_track, clock, reset, 32'(limit_ff) == MAX_DEMAND * 32'(customers_ff), "top of distribution lost track of customers")
   `TDDP_ASSERT(a_cust_bound, clock, reset, 32'(customers_ff) <= MAX_CUSTOMERS, "customer count beyond capacity")
   `TDDP_ASSERT(a_accept_quiet, clock, reset, accept |-> !mac_busy, "request taken while fold still in flight")

endmodule
